FILE: hdl/rbsi_pkg.sv
// Shared types and constants for the ray versus box slab test.
`timescale 1ns / 1ps
`default_nettype none

package rbsi_pkg;

  // Number of spatial axes handled side by side.
  localparam int AXES = 3;

  // Configuration register index width and register indexes.
  localparam int CFG_IDX_W = 3;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_CENTER_X    = 3'd0;
  localparam cfg_idx_t REG_CENTER_Y    = 3'd1;
  localparam cfg_idx_t REG_CENTER_Z    = 3'd2;
  localparam cfg_idx_t REG_HALF_WIDTH  = 3'd3;
  localparam cfg_idx_t REG_HALF_HEIGHT = 3'd4;
  localparam cfg_idx_t REG_HALF_DEPTH  = 3'd5;

  // Status of one axis as it leaves its lane.
  typedef struct packed {
    logic vld;   // a transaction is present in this slot
    logic zero;  // direction on this axis is zero
    logic miss;  // origin lies outside the slab on this axis
  } lane_flags_t;

endpackage : rbsi_pkg

`default_nettype wire

FILE: hdl/ray_box_slab_intersect_unit.sv
// Top level of the ray versus axis-aligned box slab test.
//
// A ray is taken on any cycle where start is high and busy is low; busy is high
// only during reset and in the cycle that follows it, so one ray per clock is
// accepted. Each ray yields exactly one transaction on the result ports, with
// out_valid high for a single cycle. The plane-distance dividers resolve one
// quotient bit per pipeline stage; six of them run side by side, two per axis.
// The receiver cannot stall, so results must be taken as they appear. Box
// registers must be written through the cfg port only while no ray is in
// flight; the block itself does not enforce this.
`timescale 1ns / 1ps
`default_nettype none

module ray_box_slab_intersect_unit #(
  parameter int COORD_BITS = 32,
  parameter int FRAC_BITS  = 16
) (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           start,
  output logic                          busy,
  input  wire signed [COORD_BITS-1:0]   in_origin_x,
  input  wire signed [COORD_BITS-1:0]   in_origin_y,
  input  wire signed [COORD_BITS-1:0]   in_origin_z,
  input  wire signed [COORD_BITS-1:0]   in_dir_x,
  input  wire signed [COORD_BITS-1:0]   in_dir_y,
  input  wire signed [COORD_BITS-1:0]   in_dir_z,
  input  wire                           cfg_we,
  input  rbsi_pkg::cfg_idx_t            cfg_index,
  input  wire        [COORD_BITS-1:0]   cfg_data,
  output logic                          out_valid,
  output logic                          out_hit,
  output logic       [COORD_BITS-2:0]   out_t_near,
  output logic       [COORD_BITS-2:0]   out_t_far
);

  localparam int C    = COORD_BITS;
  localparam int AXES = rbsi_pkg::AXES;

  // Box configuration registers.
  logic signed [C-1:0] ctr_r  [0:AXES-1];
  logic        [C-2:0] half_r [0:AXES-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int a = 0; a < AXES; a++) begin
        ctr_r[a]  <= '0;
        half_r[a] <= '0;
      end
    end else if (cfg_we) begin
      case (cfg_index)
        rbsi_pkg::REG_CENTER_X:    ctr_r[0]  <= $signed(cfg_data);
        rbsi_pkg::REG_CENTER_Y:    ctr_r[1]  <= $signed(cfg_data);
        rbsi_pkg::REG_CENTER_Z:    ctr_r[2]  <= $signed(cfg_data);
        rbsi_pkg::REG_HALF_WIDTH:  half_r[0] <= cfg_data[C-2:0];
        rbsi_pkg::REG_HALF_HEIGHT: half_r[1] <= cfg_data[C-2:0];
        rbsi_pkg::REG_HALF_DEPTH:  half_r[2] <= cfg_data[C-2:0];
        default: ;
      endcase
    end
  end

  // Slab planes, recomputed every cycle from the box registers.
  logic signed [C:0] lo_r [0:AXES-1];
  logic signed [C:0] hi_r [0:AXES-1];

  always_ff @(posedge clk) begin
    for (int a = 0; a < AXES; a++) begin
      lo_r[a] <= (C+1)'(ctr_r[a]) - $signed({2'b00, half_r[a]});
      hi_r[a] <= (C+1)'(ctr_r[a]) + $signed({2'b00, half_r[a]});
    end
  end

  // Busy covers reset and the cycle right after it.
  logic busy_r;
  logic accept;

  assign accept = start && !busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  assign busy = busy_r;

  // Input register stage.
  logic                in_vld_r;
  logic signed [C-1:0] org_r [0:AXES-1];
  logic signed [C-1:0] dir_r [0:AXES-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    org_r[0] <= in_origin_x;
    org_r[1] <= in_origin_y;
    org_r[2] <= in_origin_z;
    dir_r[0] <= in_dir_x;
    dir_r[1] <= in_dir_y;
    dir_r[2] <= in_dir_z;
  end

  // One lane per axis.
  rbsi_pkg::lane_flags_t lane_flags [0:AXES-1];
  logic signed [C-1:0]   lane_t_lo  [0:AXES-1];
  logic signed [C-1:0]   lane_t_hi  [0:AXES-1];

  for (genvar a = 0; a < AXES; a++) begin : g_lane
    rbsi_axis_lane #(
      .COORD_BITS (COORD_BITS),
      .FRAC_BITS  (FRAC_BITS)
    ) u_lane (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_vld    (in_vld_r),
      .in_org    (org_r[a]),
      .in_dir    (dir_r[a]),
      .in_lo     (lo_r[a]),
      .in_hi     (hi_r[a]),
      .out_flags (lane_flags[a]),
      .out_t_lo  (lane_t_lo[a]),
      .out_t_hi  (lane_t_hi[a])
    );
  end

  // Combine the axes into the final result.
  rbsi_fold #(
    .COORD_BITS (COORD_BITS)
  ) u_fold (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_flags   (lane_flags),
    .in_t_a     (lane_t_lo),
    .in_t_b     (lane_t_hi),
    .out_valid  (out_valid),
    .out_hit    (out_hit),
    .out_t_near (out_t_near),
    .out_t_far  (out_t_far)
  );

  // The three lanes must stay in lockstep.
  assert property (@(posedge clk) disable iff (!rst_n)
    (lane_flags[0].vld == lane_flags[1].vld) && (lane_flags[0].vld == lane_flags[2].vld))
    else $error("axis lanes out of step");

  // A hit never has its entry beyond its exit.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_hit) |-> (out_t_near <= out_t_far))
    else $error("hit with t_near above t_far");

  // A miss reports zero distances.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_hit) |-> ((out_t_near == '0) && (out_t_far == '0)))
    else $error("miss with nonzero distance");

  // Busy is only raised straight after reset.
  assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> !busy)
    else $error("busy raised outside reset recovery");

endmodule : ray_box_slab_intersect_unit

`default_nettype wire

FILE: hdl/rbsi_div_pipe.sv
// Pipelined signed restoring divider, one quotient bit per stage, saturating result.
`timescale 1ns / 1ps
`default_nettype none

module rbsi_div_pipe #(
  parameter int COORD_BITS = 32,
  parameter int FRAC_BITS  = 16,
  parameter int TAG_W      = 2
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_vld,
  input  wire        [TAG_W-1:0]       in_tag,
  input  wire signed [COORD_BITS+1:0]  in_num,
  input  wire signed [COORD_BITS-1:0]  in_den,
  output logic                         out_vld,
  output logic       [TAG_W-1:0]       out_tag,
  output logic signed [COORD_BITS-1:0] out_quo
);

  localparam int C     = COORD_BITS;
  localparam int NUM_W = C + 2;
  localparam int MAG_W = C + 1;
  localparam int DIV_W = MAG_W + FRAC_BITS;
  localparam int HI_W  = DIV_W - C;
  localparam int CMP_W = (HI_W > C) ? HI_W : C;

  localparam logic [C-1:0] Q_MAX = {1'b0, {(C-1){1'b1}}};
  localparam logic [C-1:0] Q_MIN = {1'b1, {(C-1){1'b0}}};

  // Stage one: magnitudes and quotient sign.
  logic [MAG_W-1:0] num_abs;
  logic [C-1:0]     den_abs;
  logic             s1_vld_r;
  logic [TAG_W-1:0] s1_tag_r;
  logic [MAG_W-1:0] s1_num_r;
  logic [C-1:0]     s1_den_r;
  logic             s1_neg_r;

  assign num_abs = in_num[NUM_W-1] ? MAG_W'(-in_num) : MAG_W'(in_num);
  assign den_abs = in_den[C-1] ? C'(-in_den) : C'(in_den);

  // Stage two: scale the dividend, check for overflow and seed the remainder.
  logic [DIV_W-1:0] dividend;
  logic [HI_W-1:0]  div_hi;
  logic             ovf_init;

  assign dividend = DIV_W'(s1_num_r) << FRAC_BITS;
  assign div_hi   = dividend[DIV_W-1:C];
  assign ovf_init = CMP_W'(div_hi) >= CMP_W'(s1_den_r);

  // Bit stages; slot 0 holds the seeded remainder.
  logic [C-1:0]     rem_r [0:C];
  logic [C-1:0]     low_r [0:C];
  logic [C-1:0]     quo_r [0:C];
  logic [C-1:0]     den_r [0:C];
  logic             neg_r [0:C];
  logic             ovf_r [0:C];
  logic             vld_r [0:C];
  logic [TAG_W-1:0] tag_r [0:C];

  logic [C-1:0]     rem_nxt [0:C-1];
  logic             bit_nxt [0:C-1];

  // Trial subtraction for each bit stage.
  always_comb begin
    logic [C:0] trial;
    logic [C:0] diff;
    for (int k = 0; k < C; k++) begin
      trial      = {rem_r[k], low_r[k][C-1]};
      diff       = trial - {1'b0, den_r[k]};
      bit_nxt[k] = trial >= {1'b0, den_r[k]};
      rem_nxt[k] = bit_nxt[k] ? diff[C-1:0] : trial[C-1:0];
    end
  end

  // Final stage: sign and saturation.
  logic [C-1:0] mag;
  logic         sat;
  logic [C-1:0] quo_nxt;

  assign mag = quo_r[C];
  assign sat = ovf_r[C] || mag[C-1];

  always_comb begin
    if (sat) begin
      quo_nxt = neg_r[C] ? Q_MIN : Q_MAX;
    end else begin
      quo_nxt = neg_r[C] ? C'(-mag) : mag;
    end
  end

  logic             out_vld_r;
  logic [TAG_W-1:0] out_tag_r;
  logic [C-1:0]     out_quo_r;

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      for (int k = 0; k <= C; k++) begin
        vld_r[k] <= 1'b0;
      end
    end else begin
      s1_vld_r <= in_vld;
      vld_r[0] <= s1_vld_r;
      for (int k = 0; k < C; k++) begin
        vld_r[k+1] <= vld_r[k];
      end
      out_vld_r <= vld_r[C];
    end
  end

  // Data path registers.
  always_ff @(posedge clk) begin
    s1_tag_r <= in_tag;
    s1_num_r <= num_abs;
    s1_den_r <= den_abs;
    s1_neg_r <= in_num[NUM_W-1] ^ in_den[C-1];

    rem_r[0] <= C'(div_hi);
    low_r[0] <= dividend[C-1:0];
    quo_r[0] <= '0;
    den_r[0] <= s1_den_r;
    neg_r[0] <= s1_neg_r;
    ovf_r[0] <= ovf_init;
    tag_r[0] <= s1_tag_r;

    for (int k = 0; k < C; k++) begin
      rem_r[k+1] <= rem_nxt[k];
      low_r[k+1] <= {low_r[k][C-2:0], 1'b0};
      quo_r[k+1] <= {quo_r[k][C-2:0], bit_nxt[k]};
      den_r[k+1] <= den_r[k];
      neg_r[k+1] <= neg_r[k];
      ovf_r[k+1] <= ovf_r[k];
      tag_r[k+1] <= tag_r[k];
    end

    out_tag_r <= tag_r[C];
    out_quo_r <= quo_nxt;
  end

  assign out_vld = out_vld_r;
  assign out_tag = out_tag_r;
  assign out_quo = $signed(out_quo_r);

endmodule : rbsi_div_pipe

`default_nettype wire

FILE: hdl/rbsi_axis_lane.sv
// One axis: plane offsets, zero-direction slab test and two plane-distance dividers.
`timescale 1ns / 1ps
`default_nettype none

module rbsi_axis_lane #(
  parameter int COORD_BITS = 32,
  parameter int FRAC_BITS  = 16
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_vld,
  input  wire signed [COORD_BITS-1:0]  in_org,
  input  wire signed [COORD_BITS-1:0]  in_dir,
  input  wire signed [COORD_BITS:0]    in_lo,
  input  wire signed [COORD_BITS:0]    in_hi,
  output rbsi_pkg::lane_flags_t        out_flags,
  output logic signed [COORD_BITS-1:0] out_t_lo,
  output logic signed [COORD_BITS-1:0] out_t_hi
);

  localparam int C     = COORD_BITS;
  localparam int NUM_W = C + 2;

  // Offsets of both planes from the origin, and the slab test for a flat direction.
  logic signed [NUM_W-1:0] dlo_nxt;
  logic signed [NUM_W-1:0] dhi_nxt;
  logic                    miss_nxt;

  assign dlo_nxt  = NUM_W'(in_lo) - NUM_W'(in_org);
  assign dhi_nxt  = NUM_W'(in_hi) - NUM_W'(in_org);
  assign miss_nxt = ((C+1)'(in_org) < in_lo) || ((C+1)'(in_org) > in_hi);

  logic                    vld_r;
  logic signed [NUM_W-1:0] dlo_r;
  logic signed [NUM_W-1:0] dhi_r;
  logic signed [C-1:0]     dir_r;
  logic                    zero_r;
  logic                    miss_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    dlo_r  <= dlo_nxt;
    dhi_r  <= dhi_nxt;
    dir_r  <= in_dir;
    zero_r <= (in_dir == '0);
    miss_r <= miss_nxt;
  end

  // The low-plane divider carries the lane flags alongside its quotient.
  logic       div_vld;
  logic [1:0] div_tag;

  rbsi_div_pipe #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS),
    .TAG_W      (2)
  ) u_div_lo (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (vld_r),
    .in_tag  ({zero_r, miss_r}),
    .in_num  (dlo_r),
    .in_den  (dir_r),
    .out_vld (div_vld),
    .out_tag (div_tag),
    .out_quo (out_t_lo)
  );

  rbsi_div_pipe #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS),
    .TAG_W      (1)
  ) u_div_hi (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (vld_r),
    .in_tag  (1'b0),
    .in_num  (dhi_r),
    .in_den  (dir_r),
    .out_vld (),
    .out_tag (),
    .out_quo (out_t_hi)
  );

  assign out_flags.vld  = div_vld;
  assign out_flags.zero = div_tag[1];
  assign out_flags.miss = div_tag[0];

endmodule : rbsi_axis_lane

`default_nettype wire

FILE: hdl/rbsi_fold.sv
// Orders each axis's plane distances and folds the three axes into near, far and hit.
`timescale 1ns / 1ps
`default_nettype none

module rbsi_fold #(
  parameter int COORD_BITS = 32
) (
  input  wire                         clk,
  input  wire                         rst_n,
  input  rbsi_pkg::lane_flags_t       in_flags [0:rbsi_pkg::AXES-1],
  input  wire signed [COORD_BITS-1:0] in_t_a   [0:rbsi_pkg::AXES-1],
  input  wire signed [COORD_BITS-1:0] in_t_b   [0:rbsi_pkg::AXES-1],
  output logic                        out_valid,
  output logic                        out_hit,
  output logic [COORD_BITS-2:0]       out_t_near,
  output logic [COORD_BITS-2:0]       out_t_far
);

  localparam int C = COORD_BITS;
  localparam logic signed [C-1:0] Q_MAX = {1'b0, {(C-1){1'b1}}};

  // Stage one: order each pair; a flat axis leaves near and far untouched.
  logic signed [C-1:0] lo_nxt [0:rbsi_pkg::AXES-1];
  logic signed [C-1:0] hi_nxt [0:rbsi_pkg::AXES-1];
  logic                miss_any_nxt;

  always_comb begin
    miss_any_nxt = 1'b0;
    for (int a = 0; a < rbsi_pkg::AXES; a++) begin
      if (in_flags[a].zero) begin
        lo_nxt[a] = '0;
        hi_nxt[a] = Q_MAX;
      end else if (in_t_a[a] > in_t_b[a]) begin
        lo_nxt[a] = in_t_b[a];
        hi_nxt[a] = in_t_a[a];
      end else begin
        lo_nxt[a] = in_t_a[a];
        hi_nxt[a] = in_t_b[a];
      end
      miss_any_nxt = miss_any_nxt | (in_flags[a].zero & in_flags[a].miss);
    end
  end

  logic                s1_vld_r;
  logic signed [C-1:0] s1_lo_r [0:rbsi_pkg::AXES-1];
  logic signed [C-1:0] s1_hi_r [0:rbsi_pkg::AXES-1];
  logic                s1_miss_r;

  // Stage two: first level of the max and min trees; near starts at zero.
  logic signed [C-1:0] near_a_nxt;
  logic signed [C-1:0] near_b_nxt;
  logic signed [C-1:0] far_a_nxt;

  assign near_a_nxt = (s1_lo_r[0] > s1_lo_r[1]) ? s1_lo_r[0] : s1_lo_r[1];
  assign near_b_nxt = (s1_lo_r[2] > 0) ? s1_lo_r[2] : '0;
  assign far_a_nxt  = (s1_hi_r[0] < s1_hi_r[1]) ? s1_hi_r[0] : s1_hi_r[1];

  logic                s2_vld_r;
  logic signed [C-1:0] s2_near_a_r;
  logic signed [C-1:0] s2_near_b_r;
  logic signed [C-1:0] s2_far_a_r;
  logic signed [C-1:0] s2_far_b_r;
  logic                s2_miss_r;

  // Stage three: final near and far.
  logic                s3_vld_r;
  logic signed [C-1:0] s3_near_r;
  logic signed [C-1:0] s3_far_r;
  logic                s3_miss_r;

  // Stage four: hit decision; distances are cleared on a miss.
  logic hit_nxt;
  assign hit_nxt = !s3_miss_r && (s3_near_r <= s3_far_r);

  logic         out_vld_r;
  logic         out_hit_r;
  logic [C-2:0] out_near_r;
  logic [C-2:0] out_far_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      s3_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      s1_vld_r  <= in_flags[0].vld;
      s2_vld_r  <= s1_vld_r;
      s3_vld_r  <= s2_vld_r;
      out_vld_r <= s3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_lo_r     <= lo_nxt;
    s1_hi_r     <= hi_nxt;
    s1_miss_r   <= miss_any_nxt;

    s2_near_a_r <= near_a_nxt;
    s2_near_b_r <= near_b_nxt;
    s2_far_a_r  <= far_a_nxt;
    s2_far_b_r  <= s1_hi_r[2];
    s2_miss_r   <= s1_miss_r;

    s3_near_r   <= (s2_near_a_r > s2_near_b_r) ? s2_near_a_r : s2_near_b_r;
    s3_far_r    <= (s2_far_a_r < s2_far_b_r) ? s2_far_a_r : s2_far_b_r;
    s3_miss_r   <= s2_miss_r;

    out_hit_r   <= hit_nxt;
    out_near_r  <= hit_nxt ? s3_near_r[C-2:0] : '0;
    out_far_r   <= hit_nxt ? s3_far_r[C-2:0] : '0;
  end

  assign out_valid  = out_vld_r;
  assign out_hit    = out_hit_r;
  assign out_t_near = out_near_r;
  assign out_t_far  = out_far_r;

endmodule : rbsi_fold

`default_nettype wire

FILE: tb/sv/tb_top.sv
// Self-checking testbench for the ray versus axis-aligned box slab test unit.
`timescale 1ns / 1ps

module tb_top;

  localparam int CB = 32;
  localparam int FB = 16;
  localparam int LATENCY = CB + 9;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam longint QMAX = 64'sd2147483647;
  localparam longint QMIN = -64'sd2147483648;

  typedef struct {
    logic signed [CB-1:0] org [3];
    logic signed [CB-1:0] dir [3];
  } ray_t;

  typedef struct {
    logic          hit;
    logic [CB-2:0] t_near;
    logic [CB-2:0] t_far;
  } hit_rec_t;

  // Directed row: ray plus an optional hand-written expectation.
  typedef struct {
    ray_t     ray;
    bit       fixed;
    hit_rec_t want;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [CB-1:0] in_origin_x = '0, in_origin_y = '0, in_origin_z = '0;
  logic signed [CB-1:0] in_dir_x = '0, in_dir_y = '0, in_dir_z = '0;
  logic                 cfg_we = 1'b0;
  rbsi_pkg::cfg_idx_t   cfg_index = rbsi_pkg::REG_CENTER_X;
  logic [CB-1:0]        cfg_data = '0;
  logic          out_valid, out_hit;
  logic [CB-2:0] out_t_near, out_t_far;

  ray_box_slab_intersect_unit #(.COORD_BITS(CB), .FRAC_BITS(FB)) i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_origin_x(in_origin_x), .in_origin_y(in_origin_y), .in_origin_z(in_origin_z),
    .in_dir_x(in_dir_x), .in_dir_y(in_dir_y), .in_dir_z(in_dir_z),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .out_valid(out_valid), .out_hit(out_hit),
    .out_t_near(out_t_near), .out_t_far(out_t_far)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Predictor's copy of the box registers.
  longint box_ctr [3];
  longint box_half [3];

  hit_rec_t pending_hits [$];
  int unsigned mismatches = 0;
  int unsigned rays_sent = 0;
  int unsigned results_seen = 0;
  int unsigned hits_seen = 0;
  int unsigned idle_cycles = 0;
  bit no_gaps = 1'b0;

  function automatic longint slab_dist(longint diff, longint d);
    longint q;
    q = (diff * (64'sd1 <<< FB)) / d;
    if (q > QMAX) q = QMAX;
    if (q < QMIN) q = QMIN;
    return q;
  endfunction

  function automatic hit_rec_t predict_hit(ray_t r);
    hit_rec_t res;
    longint tn, tf, o, d, lo, hi, t1, t2, tmp;
    bit h;
    tn = 0;
    tf = QMAX;
    h = 1'b1;
    for (int a = 0; a < 3 && h; a++) begin
      o = longint'(r.org[a]);
      d = longint'(r.dir[a]);
      lo = box_ctr[a] - box_half[a];
      hi = box_ctr[a] + box_half[a];
      if (d == 0) begin
        if (o < lo || o > hi) h = 1'b0;
      end else begin
        t1 = slab_dist(lo - o, d);
        t2 = slab_dist(hi - o, d);
        if (t1 > t2) begin
          tmp = t1; t1 = t2; t2 = tmp;
        end
        if (t1 > tn) tn = t1;
        if (t2 < tf) tf = t2;
        if (tn > tf || tf < 0) h = 1'b0;
      end
    end
    res.hit = h;
    res.t_near = h ? tn[CB-2:0] : '0;
    res.t_far = h ? tf[CB-2:0] : '0;
    return res;
  endfunction

  // Check each result transaction against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      results_seen++;
      if (out_hit === 1'b1) hits_seen++;
      if (pending_hits.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transaction");
      end else begin
        hit_rec_t w;
        w = pending_hits.pop_front();
        if (out_hit !== w.hit || out_t_near !== w.t_near || out_t_far !== w.t_far) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected hit=%0b near=%h far=%h, got hit=%0b near=%h far=%h",
                     w.hit, w.t_near, w.t_far, out_hit, out_t_near, out_t_far);
        end
      end
    end
  end

  // Watchdog on cycles without any accepted ray or result transaction.
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired");
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic write_reg(rbsi_pkg::cfg_idx_t idx, logic [CB-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      rbsi_pkg::REG_CENTER_X:    box_ctr[0] = longint'($signed(val));
      rbsi_pkg::REG_CENTER_Y:    box_ctr[1] = longint'($signed(val));
      rbsi_pkg::REG_CENTER_Z:    box_ctr[2] = longint'($signed(val));
      rbsi_pkg::REG_HALF_WIDTH:  box_half[0] = longint'({1'b0, val[CB-2:0]});
      rbsi_pkg::REG_HALF_HEIGHT: box_half[1] = longint'({1'b0, val[CB-2:0]});
      rbsi_pkg::REG_HALF_DEPTH:  box_half[2] = longint'({1'b0, val[CB-2:0]});
      default: ;
    endcase
  endtask

  task automatic load_box(logic [CB-1:0] cx, logic [CB-1:0] cy, logic [CB-1:0] cz,
                          logic [CB-1:0] hx, logic [CB-1:0] hy, logic [CB-1:0] hz);
    write_reg(rbsi_pkg::REG_CENTER_X, cx);
    write_reg(rbsi_pkg::REG_CENTER_Y, cy);
    write_reg(rbsi_pkg::REG_CENTER_Z, cz);
    write_reg(rbsi_pkg::REG_HALF_WIDTH, hx);
    write_reg(rbsi_pkg::REG_HALF_HEIGHT, hy);
    write_reg(rbsi_pkg::REG_HALF_DEPTH, hz);
  endtask

  // Present one ray and hold it until the unit takes it; gaps precede it at random unless no_gaps is set.
  task automatic send_ray(ray_t r, bit fixed, hit_rec_t want);
    int gap;
    if (!no_gaps && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 15);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_origin_x <= r.org[0]; in_origin_y <= r.org[1]; in_origin_z <= r.org[2];
    in_dir_x <= r.dir[0]; in_dir_y <= r.dir[1]; in_dir_z <= r.dir[2];
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_hits.push_back(fixed ? want : predict_hit(r));
    rays_sent++;
  endtask

  task automatic drain;
    start <= 1'b0;
    while (pending_hits.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  function automatic logic [CB-1:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return 32'sh8000_0000 + $urandom_range(0, 3);
      2: return 32'sh7FFF_FFFF - $urandom_range(0, 3);
      3: return $urandom_range(0, 2) == 0 ? '0 : 32'($signed($urandom_range(0, 8)) - 4);
      default: return 32'($signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000);
    endcase
  endfunction

  // A ray aimed toward the box center from an origin near it, so most axes overlap.
  function automatic ray_t aimed_ray();
    ray_t r;
    longint off;
    for (int a = 0; a < 3; a++) begin
      off = longint'($urandom_range(0, 32'h0040_0000)) - 64'sh0020_0000;
      r.org[a] = CB'(box_ctr[a] + off);
      if ($urandom_range(0, 7) == 0) r.dir[a] = '0;
      else r.dir[a] = CB'(-off / longint'($urandom_range(1, 64)) +
                          $signed($urandom_range(0, 255)) - 128);
    end
    return r;
  endfunction

  function automatic ray_t mk_ray(logic [CB-1:0] ox, logic [CB-1:0] oy, logic [CB-1:0] oz,
                                  logic [CB-1:0] dx, logic [CB-1:0] dy, logic [CB-1:0] dz);
    ray_t r;
    r.org[0] = ox; r.org[1] = oy; r.org[2] = oz;
    r.dir[0] = dx; r.dir[1] = dy; r.dir[2] = dz;
    return r;
  endfunction

  initial begin
    row_t rows [$];
    row_t rw;
    ray_t r;
    hit_rec_t miss_rec, none;
    miss_rec = '{hit: 1'b0, t_near: '0, t_far: '0};
    none = miss_rec;
    for (int a = 0; a < 3; a++) begin
      box_ctr[a] = 0;
      box_half[a] = 0;
    end
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // After reset the box is a single point at the origin.
    rw = '{ray: mk_ray(0, 0, 0, 0, 0, 0), fixed: 1, want: '{1'b1, '0, 31'h7FFF_FFFF}};
    rows.push_back(rw);
    rw = '{ray: mk_ray(1, 0, 0, 0, 0, 0), fixed: 1, want: miss_rec};
    rows.push_back(rw);
    rw = '{ray: mk_ray(32'h8000_0000, 0, 0, 0, 0, 0), fixed: 1, want: miss_rec};
    rows.push_back(rw);
    foreach (rows[i]) send_ray(rows[i].ray, rows[i].fixed, rows[i].want);
    drain();

    // Unit box at the origin; extreme fields and boundary cases.
    load_box(0, 0, 0, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
    rows.delete();
    rw = '{ray: mk_ray(32'h0001_0000, 32'hFFFF_0000, 0, 0, 0, 0), fixed: 1,
           want: '{1'b1, '0, 31'h7FFF_FFFF}};
    rows.push_back(rw);
    rw = '{ray: mk_ray(32'hFFFE_0000, 0, 0, 32'h0001_0000, 0, 0), fixed: 1,
           want: '{1'b1, 31'h0001_0000, 31'h0003_0000}};
    rows.push_back(rw);
    rw = '{ray: mk_ray(32'h0002_0000, 0, 0, 32'h0001_0000, 0, 0), fixed: 1, want: miss_rec};
    rows.push_back(rw);
    rw = '{ray: mk_ray(0, 0, 0, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000), fixed: 0,
           want: none};
    rows.push_back(rw);
    rw = '{ray: mk_ray(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                       32'h8000_0000, 32'h8000_0000), fixed: 0, want: none};
    rows.push_back(rw);
    rw = '{ray: mk_ray(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                       32'h7FFF_FFFF, 32'h7FFF_FFFF), fixed: 0, want: none};
    rows.push_back(rw);
    rw = '{ray: mk_ray(32'hFFFE_0000, 0, 0, 1, 0, 0), fixed: 0, want: none};
    rows.push_back(rw);
    rw = '{ray: mk_ray(32'hFFFE_0000, 0, 0, 32'hFFFF_FFFF, 0, 0), fixed: 0, want: none};
    rows.push_back(rw);
    rw = '{ray: mk_ray(0, 32'h0003_0000, 0, 32'h0001_0000, 32'hFFFF_0000, 32'h0000_8000),
           fixed: 0, want: none};
    rows.push_back(rw);
    rw = '{ray: mk_ray(0, 0, 32'h0001_0001, 0, 0, 0), fixed: 1, want: miss_rec};
    rows.push_back(rw);
    foreach (rows[i]) send_ray(rows[i].ray, rows[i].fixed, rows[i].want);
    drain();

    // Extreme box: centers at the range edges, largest extents on x and y, garbage in the top half bit.
    load_box(32'h7FFF_FFFF, 32'h8000_0000, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000);
    for (int i = 0; i < 6; i++) send_ray(mk_ray(rand_coord(), rand_coord(), rand_coord(),
                                                rand_coord(), rand_coord(), rand_coord()),
                                         0, none);
    drain();

    // Random phases, each with its own box.
    for (int ph = 0; ph < 8; ph++) begin
      load_box($urandom_range(0, 1) ? rand_coord() : 32'($signed($urandom_range(0, 32'h80_0000)) - 32'sh40_0000),
               $urandom_range(0, 1) ? rand_coord() : 32'($signed($urandom_range(0, 32'h80_0000)) - 32'sh40_0000),
               $urandom_range(0, 1) ? rand_coord() : 32'($signed($urandom_range(0, 32'h80_0000)) - 32'sh40_0000),
               $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, 32'h0010_0000),
               $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, 32'h0010_0000),
               $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, 32'h0010_0000));
      if (ph == 7) no_gaps = 1'b1;
      for (int i = 0; i < 210; i++) begin
        if ($urandom_range(0, 9) < 7) r = aimed_ray();
        else r = mk_ray(rand_coord(), rand_coord(), rand_coord(),
                        rand_coord(), rand_coord(), rand_coord());
        send_ray(r, 0, none);
      end
      drain();
    end

    $display("rays sent: %0d, results checked: %0d, hits: %0d, boxes: 11",
             rays_sent, results_seen, hits_seen);
    if (mismatches == 0 && pending_hits.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("mismatch count: %0d, leftover expectations: %0d",
               mismatches, pending_hits.size());
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
